### hdl/hid_keyboard_to_char_queue_defines.svh
// Assertion helpers for the RTL files; hkq_back is the one that includes them.
`ifndef HID_KEYBOARD_TO_CHAR_QUEUE_DEFINES_SVH
`define HID_KEYBOARD_TO_CHAR_QUEUE_DEFINES_SVH

// Property that must hold at every edge out of reset.
`define HKQ_ASSERT_ALWAYS(lbl, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
    else $error("assertion failed: always");

// Same-cycle implication.
`define HKQ_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed: implication");

// Next-cycle implication.
`define HKQ_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`endif

### hdl/hkq_pkg.sv
`default_nettype none
package hkq_pkg;

  localparam int QUEUE_DEPTH_DEF = 64;
  localparam int KEY_COUNT_DEF   = 128;

  localparam logic [23:0] PAUSE_RST    = 24'(50 * 1000);
  localparam logic [23:0] DEBOUNCE_RST = 24'(100 * 1000);

  // register indexes
  localparam logic [1:0] REG_PAUSE    = 2'd0;
  localparam logic [1:0] REG_DEBOUNCE = 2'd1;
  localparam logic [1:0] REG_LED_INIT = 2'd2;

  typedef enum logic [1:0] {
    CMD_KEY   = 2'd0,
    CMD_READ  = 2'd1,
    CMD_TABLE = 2'd2,
    CMD_MOUNT = 2'd3
  } cmd_t;

  localparam logic [2:0] EV_NONE    = 3'd0;
  localparam logic [2:0] EV_RESET   = 3'd1;
  localparam logic [2:0] EV_CHARSET = 3'd2;
  localparam logic [2:0] EV_CLOCK   = 3'd3;
  localparam logic [2:0] EV_MONITOR = 3'd4;
  localparam logic [2:0] EV_SAVE    = 3'd5;
  localparam logic [2:0] EV_SHOW    = 3'd6;
  localparam logic [2:0] EV_PRINT   = 3'd7;

  localparam logic [7:0] M_LCTRL  = 8'h01;
  localparam logic [7:0] M_LSHIFT = 8'h02;
  localparam logic [7:0] M_LALT   = 8'h04;
  localparam logic [7:0] M_LGUI   = 8'h08;
  localparam logic [7:0] M_RCTRL  = 8'h10;
  localparam logic [7:0] M_RSHIFT = 8'h20;
  localparam logic [7:0] M_RALT   = 8'h40;

  localparam logic [7:0] K_P      = 8'h13;
  localparam logic [7:0] K_SAVE   = 8'h2D;
  localparam logic [7:0] K_CAPS   = 8'h39;
  localparam logic [7:0] K_F1     = 8'h3A;
  localparam logic [7:0] K_F5     = 8'h3E;
  localparam logic [7:0] K_F8     = 8'h41;
  localparam logic [7:0] K_F9     = 8'h42;
  localparam logic [7:0] K_F12    = 8'h45;
  localparam logic [7:0] K_SCROLL = 8'h47;
  localparam logic [7:0] K_DEL    = 8'h4C;
  localparam logic [7:0] K_NUM    = 8'h53;
  localparam logic [7:0] K_KPDOT  = 8'h63;

  localparam logic [2:0] LED_NUM    = 3'd1;
  localparam logic [2:0] LED_CAPS   = 3'd2;
  localparam logic [2:0] LED_SCROLL = 3'd4;

  localparam logic [7:0] NO_CHAR    = 8'h80;
  localparam logic [7:0] REL_CHAR   = 8'hFF;
  localparam logic [7:0] TAB_CHAR   = 8'hFE;
  localparam logic [7:0] SPACE_CHAR = 8'h20;
  localparam logic [7:0] CASE_BIT   = 8'h20;
  localparam logic [7:0] UPPER_MASK = 8'hDF;

  typedef struct packed {
    logic [1:0] row;
    logic       ctrl_caps;
    logic       is_caps;
    logic       is_scroll;
    logic       is_num;
    logic       hot_done;
    logic       hot_print;
    logic [2:0] hot_kind;
    logic [7:0] hot_arg;
    logic [2:0] soft_kind;
    logic [7:0] soft_arg;
  } key_class_t;

  typedef struct packed {
    cmd_t        cmd;
    logic [7:0]  code;
    logic [47:0] now;
    logic [8:0]  tidx;
    logic [7:0]  tval;
    key_class_t  cls;
  } item_t;

  typedef struct packed {
    logic       set;
    logic [2:0] bits;
  } led_upd_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_EXEC,
    ST_RD_CHK,
    ST_KEY_CHK,
    ST_KEY_XLAT,
    ST_PUSH,
    ST_DONE
  } bst_t;

endpackage
`default_nettype wire

### hdl/hkq_if.sv
`default_nettype none
interface hkq_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  command;
  logic [7:0]  modifier;
  logic [7:0]  keycode;
  logic [47:0] now_time;
  logic [8:0]  table_index;
  logic [7:0]  table_value;

  modport source(output valid, command, modifier, keycode, now_time, table_index,
                 table_value, input ready);
  modport sink(input valid, command, modifier, keycode, now_time, table_index,
               table_value, output ready);
endinterface

interface hkq_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] event_kind;
  logic [7:0] event_arg;
  logic       char_valid;
  logic [7:0] char_code;
  logic       led_write;
  logic [2:0] led_bits;
  logic       print_flag;
  logic       queue_overflow;

  modport source(output valid, event_kind, event_arg, char_valid, char_code, led_write,
                 led_bits, print_flag, queue_overflow, input ready);
  modport sink(input valid, event_kind, event_arg, char_valid, char_code, led_write,
               led_bits, print_flag, queue_overflow, output ready);
endinterface
`default_nettype wire

### hdl/hid_keyboard_to_char_queue.sv
// Keyboard report to character queue.
// in_ch takes one request per handshake: key report, read character, table
// write or device mount, each with a microsecond timestamp. out_ch returns
// exactly one result per request, in order.
// Requests enter a two-entry classify queue, so in_ch stays ready while the
// back end works or while a result waits on out_ch.
// A key that translates to tab writes eight queue entries. The back-end
// sequencer handles one request at a time and makes one character-queue
// write per cycle in its push state, dropping the entry and flagging
// overflow while the queue is full.
// A stalled out_ch holds the finished result; the back end waits in its
// done state, and in_ch drops ready once both classify slots fill.
// Reset (rst_n low, synchronous) clears pointers, LEDs, timers, print state
// and the handshakes; table and queue contents stay as they were.
// cfg_ is APB: reg 0 pause, reg 1 debounce, reg 2 led_init at 4*i. LED
// toggles also rewrite led_init. Write config only while the block is idle.
`default_nettype none
module hid_keyboard_to_char_queue #(
  parameter int QUEUE_DEPTH = hkq_pkg::QUEUE_DEPTH_DEF,
  parameter int KEY_COUNT   = hkq_pkg::KEY_COUNT_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  hkq_in_if.sink           in_ch,
  hkq_out_if.source        out_ch,
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [3:0]  cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  output logic [31:0]      cfg_prdata,
  output logic             cfg_pready
);

  logic [23:0]       pause_r, debounce_r;
  logic [2:0]        led_init_r;
  logic              cfg_wr;
  logic [1:0]        reg_idx;
  hkq_pkg::item_t    head;
  logic              head_valid, pop;
  hkq_pkg::led_upd_t led_upd;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;
  assign reg_idx    = cfg_paddr[3:2];

  // register file; back end rewrites led_init on every lock toggle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pause_r    <= hkq_pkg::PAUSE_RST;
      debounce_r <= hkq_pkg::DEBOUNCE_RST;
      led_init_r <= 3'd0;
    end else begin
      if (cfg_wr) begin
        case (reg_idx)
          hkq_pkg::REG_PAUSE:    pause_r    <= cfg_pwdata[23:0];
          hkq_pkg::REG_DEBOUNCE: debounce_r <= cfg_pwdata[23:0];
          hkq_pkg::REG_LED_INIT: led_init_r <= cfg_pwdata[2:0];
          default: ;
        endcase
      end
      if (led_upd.set) led_init_r <= led_upd.bits;
    end
  end

  always_comb begin
    case (reg_idx)
      hkq_pkg::REG_PAUSE:    cfg_prdata = {8'd0, pause_r};
      hkq_pkg::REG_DEBOUNCE: cfg_prdata = {8'd0, debounce_r};
      hkq_pkg::REG_LED_INIT: cfg_prdata = {29'd0, led_init_r};
      default:               cfg_prdata = 32'd0;
    endcase
  end

  // front: accept and classify
  hkq_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .head       (head),
    .head_valid (head_valid),
    .pop        (pop)
  );

  // back: table, character queue, LEDs and timers
  hkq_back #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .KEY_COUNT   (KEY_COUNT)
  ) u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .head           (head),
    .head_valid     (head_valid),
    .pop            (pop),
    .pause_ticks    (pause_r),
    .debounce_ticks (debounce_r),
    .led_init       (led_init_r),
    .led_upd        (led_upd),
    .out_ch         (out_ch)
  );

endmodule
`default_nettype wire

### hdl/hkq_front.sv
`default_nettype none
module hkq_front (
  input  wire logic         clk,
  input  wire logic         rst_n,
  hkq_in_if.sink            in_ch,
  output hkq_pkg::item_t    head,
  output logic              head_valid,
  input  wire logic         pop
);

  hkq_pkg::item_t    slot_r [2];
  logic [1:0]        fill_r, fill_nxt;
  logic              rd_r, rd_nxt, wr_r, wr_nxt;
  hkq_pkg::item_t    cur;
  hkq_pkg::key_class_t cls;
  logic              push;
  logic [7:0]        md, kc;

  assign md = in_ch.modifier;
  assign kc = in_ch.keycode;

  // stateless decode of the report
  always_comb begin
    cls = '0;
    if ((md & (hkq_pkg::M_LSHIFT | hkq_pkg::M_RSHIFT)) != 8'd0) cls.row = cls.row | 2'd1;
    if ((md & (hkq_pkg::M_LCTRL | hkq_pkg::M_RCTRL)) != 8'd0) cls.row = cls.row | 2'd2;
    if ((md & (hkq_pkg::M_LALT | hkq_pkg::M_RALT)) != 8'd0) cls.row = cls.row | 2'd3;
    cls.ctrl_caps = (md == hkq_pkg::M_LCTRL) && (kc == hkq_pkg::K_CAPS);
    cls.is_caps   = (kc == hkq_pkg::K_CAPS);
    cls.is_scroll = (kc == hkq_pkg::K_SCROLL);
    cls.is_num    = (kc == hkq_pkg::K_NUM);
    if (md == (hkq_pkg::M_LCTRL | hkq_pkg::M_LALT) &&
        (kc == hkq_pkg::K_KPDOT || kc == hkq_pkg::K_DEL)) begin
      cls.hot_done = 1'b1;
      cls.hot_kind = hkq_pkg::EV_RESET;
    end else if (md == hkq_pkg::M_LALT && kc inside {[hkq_pkg::K_F5:hkq_pkg::K_F12]}) begin
      cls.hot_done = 1'b1;
      if (kc < hkq_pkg::K_F8) begin
        cls.hot_kind = hkq_pkg::EV_CHARSET;
        cls.hot_arg  = kc - hkq_pkg::K_F5;
      end else if (kc >= hkq_pkg::K_F9) begin
        cls.hot_kind = hkq_pkg::EV_CLOCK;
        cls.hot_arg  = kc - hkq_pkg::K_F9;
      end
    end else if (md == hkq_pkg::M_RALT && kc >= hkq_pkg::K_F5 && kc < hkq_pkg::K_F8) begin
      cls.hot_done = 1'b1;
      cls.hot_kind = hkq_pkg::EV_CHARSET;
      cls.hot_arg  = 8'd4 + (kc - hkq_pkg::K_F5);
    end else if (md == (hkq_pkg::M_LCTRL | hkq_pkg::M_LALT) &&
                 kc >= hkq_pkg::K_F1 && kc < hkq_pkg::K_F5) begin
      cls.hot_done = 1'b1;
      cls.hot_kind = hkq_pkg::EV_MONITOR;
      cls.hot_arg  = kc - hkq_pkg::K_F1;
    end else if (md == (hkq_pkg::M_LCTRL | hkq_pkg::M_LALT) && kc == hkq_pkg::K_P) begin
      cls.hot_done  = 1'b1;
      cls.hot_print = 1'b1;
      cls.hot_kind  = hkq_pkg::EV_PRINT;
    end
    if (md == (hkq_pkg::M_LGUI | hkq_pkg::M_LCTRL) && kc == hkq_pkg::K_SAVE)
      cls.soft_kind = hkq_pkg::EV_SAVE;
    if (md == (hkq_pkg::M_LGUI | hkq_pkg::M_LSHIFT) && kc != 8'd0) begin
      cls.soft_kind = hkq_pkg::EV_SHOW;
      cls.soft_arg  = kc;
    end
  end

  always_comb begin
    cur.cmd  = hkq_pkg::cmd_t'(in_ch.command);
    cur.code = kc;
    cur.now  = in_ch.now_time;
    cur.tidx = in_ch.table_index;
    cur.tval = in_ch.table_value;
    cur.cls  = cls;
  end

  assign in_ch.ready = (fill_r != 2'd2);
  assign push        = in_ch.valid && in_ch.ready;
  assign head_valid  = (fill_r != 2'd0);
  assign head        = slot_r[rd_r];

  always_comb begin
    fill_nxt = fill_r + {1'b0, push} - {1'b0, pop};
    rd_nxt   = pop ? ~rd_r : rd_r;
    wr_nxt   = push ? ~wr_r : wr_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= 2'd0;
      rd_r   <= 1'b0;
      wr_r   <= 1'b0;
    end else begin
      fill_r <= fill_nxt;
      rd_r   <= rd_nxt;
      wr_r   <= wr_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) slot_r[wr_r] <= cur;
  end

endmodule
`default_nettype wire

### hdl/hkq_back.sv
`default_nettype none
`include "hid_keyboard_to_char_queue_defines.svh"
module hkq_back #(
  parameter int QUEUE_DEPTH = hkq_pkg::QUEUE_DEPTH_DEF,
  parameter int KEY_COUNT   = hkq_pkg::KEY_COUNT_DEF
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire hkq_pkg::item_t head,
  input  wire logic          head_valid,
  output logic               pop,
  input  wire logic [23:0]   pause_ticks,
  input  wire logic [23:0]   debounce_ticks,
  input  wire logic [2:0]    led_init,
  output hkq_pkg::led_upd_t  led_upd,
  hkq_out_if.source          out_ch
);

  localparam int TABLE_SIZE = KEY_COUNT * 4;
  localparam int TW = $clog2(TABLE_SIZE);
  localparam int PW = $clog2(2 * QUEUE_DEPTH);
  localparam int SW = $clog2(QUEUE_DEPTH);

  logic [7:0] table_mem [TABLE_SIZE];
  logic [7:0] queue_mem [QUEUE_DEPTH];

  hkq_pkg::bst_t   st_r, st_nxt;
  hkq_pkg::item_t  it_r;
  logic [PW-1:0]   wp_r, wp_nxt, rp_r, rp_nxt;
  logic [2:0]      leds_r, leds_nxt;
  logic [7:0]      prev_r, prev_nxt;
  logic            print_r, print_nxt;
  logic [47:0]     rel_t_r, rel_t_nxt, prs_t_r, prs_t_nxt;
  logic [47:0]     caps_t_r, caps_t_nxt, scr_t_r, scr_t_nxt, num_t_r, num_t_nxt;
  logic [2:0]      kind_r, kind_nxt;
  logic [7:0]      arg_r, arg_nxt;
  logic            cval_r, cval_nxt;
  logic [7:0]      cchar_r, cchar_nxt;
  logic            lwr_r, lwr_nxt;
  logic            ovf_r, ovf_nxt;
  logic            e_caps_r, e_scr_r, e_num_r;
  logic            tab_r, tab_nxt;
  logic [2:0]      cnt_r, cnt_nxt;
  logic [7:0]      pch_r, pch_nxt;
  logic            oval_r;
  logic [7:0]      q_rdata_r, t_rdata_r;

  logic [PW:0]     q_count;
  logic            q_full;
  logic [SW-1:0]   rd_slot, wr_slot;
  logic [TW-1:0]   t_raddr;
  logic            key_in_range, tbl_ok;
  logic            ld_item, ld_out, t_we, q_we, ld_elapsed;
  logic [7:0]      q_wdata, xch;
  logic            e_rel, e_prs, e_caps, e_scr, e_num;

  function automatic logic [PW-1:0] slot_of(input logic [PW-1:0] p);
    logic [PW:0] pe;
    pe = {1'b0, p};
    return (pe >= (PW+1)'(QUEUE_DEPTH)) ? PW'(pe - (PW+1)'(QUEUE_DEPTH)) : p;
  endfunction

  function automatic logic [PW-1:0] next_of(input logic [PW-1:0] p);
    logic [PW:0] pe;
    pe = {1'b0, p} + (PW+1)'(1);
    return (pe >= (PW+1)'(2 * QUEUE_DEPTH)) ? '0 : PW'(pe);
  endfunction

  function automatic logic late(input logic [47:0] now, input logic [47:0] since,
                                input logic [23:0] gap);
    return {1'b0, now} > ({1'b0, since} + {25'd0, gap});
  endfunction

  always_comb begin
    if (wp_r >= rp_r) q_count = {1'b0, wp_r} - {1'b0, rp_r};
    else q_count = {1'b0, wp_r} + (PW+1)'(2 * QUEUE_DEPTH) - {1'b0, rp_r};
  end
  assign q_full  = q_count >= (PW+1)'(QUEUE_DEPTH);
  assign rd_slot = SW'(slot_of(rp_r));
  assign wr_slot = SW'(slot_of(wp_r));

  assign key_in_range = {1'b0, it_r.code} < 9'(KEY_COUNT);
  assign tbl_ok       = {2'b0, it_r.tidx} < 11'(TABLE_SIZE);
  assign t_raddr      = TW'({it_r.code, it_r.cls.row});

  assign e_rel  = late(it_r.now, rel_t_r, pause_ticks);
  assign e_prs  = late(it_r.now, prs_t_r, pause_ticks);
  assign e_caps = late(it_r.now, caps_t_r, debounce_ticks);
  assign e_scr  = late(it_r.now, scr_t_r, debounce_ticks);
  assign e_num  = late(it_r.now, num_t_r, debounce_ticks);

  // caps-lock case flip of the table code
  always_comb begin
    xch = t_rdata_r;
    if ((leds_r & hkq_pkg::LED_CAPS) != 3'd0) begin
      if (t_rdata_r inside {[8'h41:8'h5D]}) xch = t_rdata_r | hkq_pkg::CASE_BIT;
      else if (t_rdata_r inside {[8'h61:8'h7D]}) xch = t_rdata_r & hkq_pkg::UPPER_MASK;
    end
  end

  // next state
  always_comb begin
    st_nxt = st_r;
    case (st_r)
      hkq_pkg::ST_IDLE: if (head_valid) st_nxt = hkq_pkg::ST_EXEC;
      hkq_pkg::ST_EXEC: begin
        case (it_r.cmd)
          hkq_pkg::CMD_READ: st_nxt = hkq_pkg::ST_RD_CHK;
          hkq_pkg::CMD_KEY:  st_nxt = hkq_pkg::ST_KEY_CHK;
          default:           st_nxt = hkq_pkg::ST_DONE;
        endcase
      end
      hkq_pkg::ST_RD_CHK: st_nxt = hkq_pkg::ST_DONE;
      hkq_pkg::ST_KEY_CHK: begin
        if ((it_r.cls.ctrl_caps && e_num_r) || (it_r.cls.is_caps && e_caps_r) ||
            (it_r.cls.is_scroll && e_scr_r) || (it_r.cls.is_num && e_num_r) ||
            it_r.cls.hot_done || !key_in_range)
          st_nxt = hkq_pkg::ST_DONE;
        else
          st_nxt = hkq_pkg::ST_KEY_XLAT;
      end
      hkq_pkg::ST_KEY_XLAT: st_nxt = (xch != prev_r) ? hkq_pkg::ST_PUSH : hkq_pkg::ST_DONE;
      hkq_pkg::ST_PUSH: if (!tab_r || cnt_r == 3'd7) st_nxt = hkq_pkg::ST_DONE;
      hkq_pkg::ST_DONE: if (!oval_r || out_ch.ready) st_nxt = hkq_pkg::ST_IDLE;
      default: st_nxt = hkq_pkg::ST_IDLE;
    endcase
  end

  // datapath controls
  always_comb begin
    pop = 1'b0; ld_item = 1'b0; ld_out = 1'b0; t_we = 1'b0; q_we = 1'b0;
    ld_elapsed = 1'b0;
    q_wdata = tab_r ? (cnt_r[0] ? hkq_pkg::REL_CHAR : hkq_pkg::SPACE_CHAR) : pch_r;
    wp_nxt = wp_r; rp_nxt = rp_r; leds_nxt = leds_r; prev_nxt = prev_r;
    print_nxt = print_r; rel_t_nxt = rel_t_r; prs_t_nxt = prs_t_r;
    caps_t_nxt = caps_t_r; scr_t_nxt = scr_t_r; num_t_nxt = num_t_r;
    kind_nxt = kind_r; arg_nxt = arg_r; cval_nxt = cval_r; cchar_nxt = cchar_r;
    lwr_nxt = lwr_r; ovf_nxt = ovf_r; tab_nxt = tab_r; cnt_nxt = cnt_r; pch_nxt = pch_r;
    led_upd = '0;
    case (st_r)
      hkq_pkg::ST_IDLE: begin
        if (head_valid) begin
          pop = 1'b1; ld_item = 1'b1;
          kind_nxt = hkq_pkg::EV_NONE; arg_nxt = 8'd0; cval_nxt = 1'b0;
          cchar_nxt = hkq_pkg::NO_CHAR; lwr_nxt = 1'b0; ovf_nxt = 1'b0;
        end
      end
      hkq_pkg::ST_EXEC: begin
        ld_elapsed = 1'b1;
        case (it_r.cmd)
          hkq_pkg::CMD_TABLE: t_we = tbl_ok;
          hkq_pkg::CMD_MOUNT: begin
            leds_nxt = led_init;
            lwr_nxt  = 1'b1;
          end
          default: ;
        endcase
      end
      hkq_pkg::ST_RD_CHK: begin
        if (q_count != '0 && e_rel && e_prs) begin
          rp_nxt    = next_of(rp_r);
          cval_nxt  = 1'b1;
          cchar_nxt = q_rdata_r;
          if (q_rdata_r == hkq_pkg::REL_CHAR) rel_t_nxt = it_r.now;
          else prs_t_nxt = it_r.now;
        end
      end
      hkq_pkg::ST_KEY_CHK: begin
        if (it_r.cls.ctrl_caps && e_num_r) begin
          leds_nxt = leds_r ^ hkq_pkg::LED_SCROLL; num_t_nxt = it_r.now; lwr_nxt = 1'b1;
          led_upd = '{set: 1'b1, bits: leds_r ^ hkq_pkg::LED_SCROLL};
        end else if (it_r.cls.is_caps && e_caps_r) begin
          leds_nxt = leds_r ^ hkq_pkg::LED_CAPS; caps_t_nxt = it_r.now; lwr_nxt = 1'b1;
          led_upd = '{set: 1'b1, bits: leds_r ^ hkq_pkg::LED_CAPS};
        end else if (it_r.cls.is_scroll && e_scr_r) begin
          leds_nxt = leds_r ^ hkq_pkg::LED_SCROLL; scr_t_nxt = it_r.now; lwr_nxt = 1'b1;
          led_upd = '{set: 1'b1, bits: leds_r ^ hkq_pkg::LED_SCROLL};
        end else if (it_r.cls.is_num && e_num_r) begin
          leds_nxt = leds_r ^ hkq_pkg::LED_NUM; num_t_nxt = it_r.now; lwr_nxt = 1'b1;
          led_upd = '{set: 1'b1, bits: leds_r ^ hkq_pkg::LED_NUM};
        end else if (it_r.cls.hot_done) begin
          kind_nxt = it_r.cls.hot_kind;
          arg_nxt  = it_r.cls.hot_arg;
          if (it_r.cls.hot_print) print_nxt = ~print_r;
        end else begin
          kind_nxt = it_r.cls.soft_kind;
          arg_nxt  = it_r.cls.soft_arg;
        end
      end
      hkq_pkg::ST_KEY_XLAT: begin
        cnt_nxt = 3'd0;
        if (xch != prev_r) begin
          if (xch == hkq_pkg::TAB_CHAR) begin
            tab_nxt = 1'b1; prev_nxt = hkq_pkg::REL_CHAR;
          end else begin
            tab_nxt = 1'b0; pch_nxt = xch; prev_nxt = xch;
          end
        end
      end
      hkq_pkg::ST_PUSH: begin
        if (q_full) ovf_nxt = 1'b1;
        else begin
          q_we   = 1'b1;
          wp_nxt = next_of(wp_r);
        end
        cnt_nxt = cnt_r + 3'd1;
      end
      hkq_pkg::ST_DONE: ld_out = !oval_r || out_ch.ready;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= hkq_pkg::ST_IDLE;
      wp_r <= '0; rp_r <= '0; leds_r <= 3'd0; prev_r <= 8'd0; print_r <= 1'b0;
      rel_t_r <= '0; prs_t_r <= '0; caps_t_r <= '0; scr_t_r <= '0; num_t_r <= '0;
      oval_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      wp_r <= wp_nxt; rp_r <= rp_nxt; leds_r <= leds_nxt; prev_r <= prev_nxt;
      print_r <= print_nxt;
      rel_t_r <= rel_t_nxt; prs_t_r <= prs_t_nxt;
      caps_t_r <= caps_t_nxt; scr_t_r <= scr_t_nxt; num_t_r <= num_t_nxt;
      if (ld_out) oval_r <= 1'b1;
      else if (out_ch.ready) oval_r <= 1'b0;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (ld_item) it_r <= head;
    if (ld_elapsed) begin
      e_caps_r <= e_caps; e_scr_r <= e_scr; e_num_r <= e_num;
    end
    kind_r <= kind_nxt; arg_r <= arg_nxt; cval_r <= cval_nxt; cchar_r <= cchar_nxt;
    lwr_r <= lwr_nxt; ovf_r <= ovf_nxt; tab_r <= tab_nxt; cnt_r <= cnt_nxt; pch_r <= pch_nxt;
    if (ld_out) begin
      out_ch.event_kind     <= kind_r;
      out_ch.event_arg      <= arg_r;
      out_ch.char_valid     <= cval_r;
      out_ch.char_code      <= cchar_r;
      out_ch.led_write      <= lwr_r;
      out_ch.led_bits       <= leds_r;
      out_ch.print_flag     <= print_r;
      out_ch.queue_overflow <= ovf_r;
    end
  end

  assign out_ch.valid = oval_r;

  // memories
  always_ff @(posedge clk) begin
    if (t_we) table_mem[TW'(it_r.tidx)] <= it_r.tval;
    t_rdata_r <= table_mem[t_raddr];
  end

  always_ff @(posedge clk) begin
    if (q_we) queue_mem[wr_slot] <= q_wdata;
    q_rdata_r <= queue_mem[rd_slot];
  end

  `HKQ_ASSERT_ALWAYS(a_count_bound, q_count <= (PW+1)'(QUEUE_DEPTH))
  `HKQ_ASSERT_IMPL(a_pop_needs_item, pop, head_valid && st_r == hkq_pkg::ST_IDLE)
  `HKQ_ASSERT_IMPL(a_no_write_when_full, q_we, !q_full)
  `HKQ_ASSERT_NEXT(a_led_upd_matches, led_upd.set, leds_r == $past(led_upd.bits))

endmodule
`default_nettype wire
